// ===== rtl/core/rbtd_pkg.sv =====
// Shared types and constants for the relative bearing turn decision block.
// Holds the CORDIC word layout, the arctangent table and the turn codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rbtd_pkg;

  // CORDIC working word: scaled offsets reach 2^60 and grow by about 2.4.
  localparam int unsigned CORD_W       = 64;
  // Angle accumulator, 2^32 per full turn.
  localparam int unsigned ZACC_W       = 32;
  // Entries in the arctangent table; deeper stages are not built.
  localparam int unsigned ATAN_ENTRIES = 24;
  // Scaled offsets are shifted so that they sit at bit 60.
  localparam int unsigned SCALE_TOP    = 60;
  // Result and register widths.
  localparam int unsigned DELTA_W      = 16;
  localparam int unsigned THRESH_W     = 16;
  localparam int unsigned APB_DATA_W   = 32;
  localparam int unsigned APB_ADDR_W   = 3;

  // Reset value of the dead zone half-width.
  localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd1820;

  // Register index taken from paddr bit 2.
  localparam logic REG_THRESHOLD = 1'b0;

  // Seed for a vector folded into the right half plane.
  localparam logic [ZACC_W-1:0] Z_HALF_TURN = 32'h8000_0000;

  typedef enum logic [1:0] {
    TURN_NONE  = 2'd0,
    TURN_RIGHT = 2'd1,
    TURN_LEFT  = 2'd2
  } turn_e;

  // State handed from cell to cell.
  typedef struct packed {
    logic              valid;
    logic              skip;
    logic [CORD_W-1:0] x;
    logic [CORD_W-1:0] y;
    logic [ZACC_W-1:0] z;
  } rbtd_vec_t;

  // atan(2^-i) in units of 2^32 per turn.
  function automatic logic [ZACC_W-1:0] atan_unit(input int unsigned idx);
    logic [ZACC_W-1:0] val;
    case (idx)
      0:       val = 32'd536870912;
      1:       val = 32'd316933405;
      2:       val = 32'd167458907;
      3:       val = 32'd85004756;
      4:       val = 32'd42667331;
      5:       val = 32'd21354465;
      6:       val = 32'd10679838;
      7:       val = 32'd5340245;
      8:       val = 32'd2670163;
      9:       val = 32'd1335087;
      10:      val = 32'd667544;
      11:      val = 32'd333772;
      12:      val = 32'd166886;
      13:      val = 32'd83443;
      14:      val = 32'd41722;
      15:      val = 32'd20861;
      16:      val = 32'd10430;
      17:      val = 32'd5215;
      18:      val = 32'd2608;
      19:      val = 32'd1304;
      20:      val = 32'd652;
      21:      val = 32'd326;
      22:      val = 32'd163;
      23:      val = 32'd81;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rbtd_prep.sv =====
// Front cell: forms the target offset, scales it and folds it into the
// right half plane. Depends on rbtd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbtd_prep
  import rbtd_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 24,
  parameter int unsigned ANGLE_WIDTH = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   advance_i,
  input  wire logic                   valid_i,
  input  wire logic                   self_present_i,
  input  wire logic                   target_present_i,
  input  wire logic [COORD_WIDTH-1:0] self_x_i,
  input  wire logic [COORD_WIDTH-1:0] self_y_i,
  input  wire logic [COORD_WIDTH-1:0] target_x_i,
  input  wire logic [COORD_WIDTH-1:0] target_y_i,
  input  wire logic [ANGLE_WIDTH-1:0] heading_i,
  output rbtd_vec_t                   vec_o,
  output logic      [ANGLE_WIDTH-1:0] heading_o
);

  localparam int unsigned SCALE_SH = SCALE_TOP - COORD_WIDTH;

  logic signed [COORD_WIDTH:0]   dx, dy;
  logic signed [CORD_W-1:0]      xs, ys;
  rbtd_vec_t                     vec_d, vec_q;
  logic        [ANGLE_WIDTH-1:0] heading_q;

  // Offset to the target, one bit wider than a coordinate.
  always_comb begin
    dx = (COORD_WIDTH+1)'($signed(target_x_i)) - (COORD_WIDTH+1)'($signed(self_x_i));
    dy = (COORD_WIDTH+1)'($signed(target_y_i)) - (COORD_WIDTH+1)'($signed(self_y_i));
    xs = CORD_W'(dx) <<< SCALE_SH;
    ys = CORD_W'(dy) <<< SCALE_SH;
  end

  // Fold a left-pointing vector and seed the angle with a half turn.
  always_comb begin
    vec_d.valid = valid_i;
    vec_d.skip  = !self_present_i || !target_present_i || (dx == '0 && dy == '0);
    if (xs < 0) begin
      vec_d.x = -xs;
      vec_d.y = -ys;
      vec_d.z = Z_HALF_TURN;
    end else begin
      vec_d.x = xs;
      vec_d.y = ys;
      vec_d.z = '0;
    end
  end

  // Hold while the chain is frozen.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vec_q     <= '0;
      heading_q <= '0;
    end else if (advance_i) begin
      vec_q     <= vec_d;
      heading_q <= heading_i;
    end
  end

  assign vec_o     = vec_q;
  assign heading_o = heading_q;

endmodule

`default_nettype wire

// ===== rtl/core/rbtd_cell.sv =====
// One vectoring CORDIC micro-rotation, registered, with the heading carried
// alongside. Depends on rbtd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbtd_cell
  import rbtd_pkg::*;
#(
  parameter int unsigned IDX         = 0,
  parameter int unsigned ANGLE_WIDTH = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   advance_i,
  input  wire rbtd_vec_t              vec_i,
  input  wire logic [ANGLE_WIDTH-1:0] heading_i,
  output rbtd_vec_t                   vec_o,
  output logic      [ANGLE_WIDTH-1:0] heading_o
);

  localparam logic [ZACC_W-1:0] ATAN_STEP = atan_unit(IDX);

  logic signed [CORD_W-1:0]      x_in, y_in, x_sh, y_sh;
  rbtd_vec_t                     vec_d, vec_q;
  logic        [ANGLE_WIDTH-1:0] heading_q;

  // Rotate toward the x axis by atan(2^-IDX).
  always_comb begin
    x_in  = vec_i.x;
    y_in  = vec_i.y;
    x_sh  = x_in >>> IDX;
    y_sh  = y_in >>> IDX;
    vec_d = vec_i;
    if (!y_in[CORD_W-1]) begin
      vec_d.x = x_in + y_sh;
      vec_d.y = y_in - x_sh;
      vec_d.z = vec_i.z + ATAN_STEP;
    end else begin
      vec_d.x = x_in - y_sh;
      vec_d.y = y_in + x_sh;
      vec_d.z = vec_i.z - ATAN_STEP;
    end
  end

  // Advance with the chain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vec_q     <= '0;
      heading_q <= '0;
    end else if (advance_i) begin
      vec_q     <= vec_d;
      heading_q <= heading_i;
    end
  end

  assign vec_o     = vec_q;
  assign heading_o = heading_q;

endmodule

`default_nettype wire

// ===== rtl/core/rbtd_decide.sv =====
// Back cell: rounds the bearing, subtracts the heading, applies the dead zone
// and holds the result beat. Depends on rbtd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbtd_decide
  import rbtd_pkg::*;
#(
  parameter int unsigned ANGLE_WIDTH = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire rbtd_vec_t              vec_i,
  input  wire logic [ANGLE_WIDTH-1:0] heading_i,
  input  wire logic [THRESH_W-1:0]    threshold_i,
  input  wire logic                   out_stall_i,
  output logic                        advance_o,
  output logic                        out_valid_o,
  output logic      [1:0]             turn_code_o,
  output logic      [DELTA_W-1:0]     angle_delta_o
);

  localparam logic [ZACC_W-1:0] ROUND_HALF = ZACC_W'(1) << (ZACC_W - 1 - ANGLE_WIDTH);
  localparam int unsigned       CMP_W      = (ANGLE_WIDTH > THRESH_W) ? ANGLE_WIDTH : THRESH_W;
  localparam int unsigned       PAD_W      = ANGLE_WIDTH + DELTA_W;

  logic [ZACC_W-1:0]      z_round;
  logic [ANGLE_WIDTH-1:0] bearing, raw, mag;
  logic                   neg, below;
  logic [PAD_W-1:0]       raw_pad;
  turn_e                  turn_d;
  logic [DELTA_W-1:0]     delta_d;
  logic                   valid_q;
  turn_e                  turn_q;
  logic [DELTA_W-1:0]     delta_q;

  // Round the accumulator to the angle width and take the heading off.
  always_comb begin
    z_round = vec_i.z + ROUND_HALF;
    bearing = z_round[ZACC_W-1 -: ANGLE_WIDTH];
    raw     = bearing - heading_i;
    neg     = raw[ANGLE_WIDTH-1];
    mag     = neg ? (~raw + ANGLE_WIDTH'(1)) : raw;
    below   = CMP_W'(mag) < CMP_W'(threshold_i);
    raw_pad = {{DELTA_W{1'b0}}, raw};
  end

  // Pick the turn; absent parties and coincident points give nothing.
  always_comb begin
    if (vec_i.skip) begin
      turn_d  = TURN_NONE;
      delta_d = '0;
    end else begin
      delta_d = raw_pad[DELTA_W-1:0];
      if (below) begin
        turn_d = TURN_NONE;
      end else if (!neg && raw != '0) begin
        turn_d = TURN_RIGHT;
      end else begin
        turn_d = TURN_LEFT;
      end
    end
  end

  // Freeze the chain only while a held beat waits downstream.
  assign advance_o = !(valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= vec_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      turn_q  <= turn_d;
      delta_q <= delta_d;
    end
  end

  assign out_valid_o   = valid_q;
  assign turn_code_o   = turn_q;
  assign angle_delta_o = delta_q;

endmodule

`default_nettype wire

// ===== rtl/core/relative_bearing_turn_decision.sv =====
// Top level of the relative bearing turn decision block: threshold register,
// front cell, chain of CORDIC cells and decision cell. Depends on rbtd_pkg,
// rbtd_prep, rbtd_cell and rbtd_decide.
//
//   channel  direction  handshake                      payload
//   in       sink       in_valid_i / in_stall_o        presence flags, positions, heading
//   out      source     out_valid_o / out_stall_i      turn_code_o, angle_delta_o
//   cfg      sink       psel/penable/pwrite, pready     threshold_angle at byte 0
//
// One beat enters per cycle while the chain is not frozen; each beat passes the
// front cell, one cell per micro-rotation (no more than the arctangent table holds) and the output register.
// Reset clears every valid flag and loads a threshold of 1820.
// A held output beat freezes the whole chain and raises in_stall_o for that
// cycle; an empty output never stalls the input.
`timescale 1ns / 1ps
`default_nettype none

module relative_bearing_turn_decision
  import rbtd_pkg::*;
#(
  parameter int unsigned COORD_WIDTH   = 24,
  parameter int unsigned ANGLE_WIDTH   = 16,
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // input channel
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic                    self_present_i,
  input  wire logic                    target_present_i,
  input  wire logic [COORD_WIDTH-1:0]  self_x_i,
  input  wire logic [COORD_WIDTH-1:0]  self_y_i,
  input  wire logic [COORD_WIDTH-1:0]  target_x_i,
  input  wire logic [COORD_WIDTH-1:0]  target_y_i,
  input  wire logic [ANGLE_WIDTH-1:0]  self_heading_i,
  // output channel
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic      [1:0]              turn_code_o,
  output logic      [DELTA_W-1:0]      angle_delta_o,
  // configuration port
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [APB_ADDR_W-1:0]   paddr,
  input  wire logic [APB_DATA_W-1:0]   pwdata,
  output logic      [APB_DATA_W-1:0]   prdata,
  output logic                         pready
);

  localparam int unsigned NUM_CELLS =
      (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

  logic                   advance;
  logic [THRESH_W-1:0]    thresh_q;
  rbtd_vec_t              vec   [0:NUM_CELLS];
  logic [ANGLE_WIDTH-1:0] hdg   [0:NUM_CELLS];

  // Configuration register.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_THRESHOLD) begin
      thresh_q <= pwdata[THRESH_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_THRESHOLD: prdata = {{(APB_DATA_W-THRESH_W){1'b0}}, thresh_q};
      default:       prdata = '0;
    endcase
  end

  // Take a beat whenever the chain moves.
  assign in_stall_o = !advance;

  rbtd_prep #(
    .COORD_WIDTH (COORD_WIDTH),
    .ANGLE_WIDTH (ANGLE_WIDTH)
  ) u_prep (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .advance_i        (advance),
    .valid_i          (in_valid_i),
    .self_present_i   (self_present_i),
    .target_present_i (target_present_i),
    .self_x_i         (self_x_i),
    .self_y_i         (self_y_i),
    .target_x_i       (target_x_i),
    .target_y_i       (target_y_i),
    .heading_i        (self_heading_i),
    .vec_o            (vec[0]),
    .heading_o        (hdg[0])
  );

  // One cell per micro-rotation.
  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    rbtd_cell #(
      .IDX         (g),
      .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (advance),
      .vec_i     (vec[g]),
      .heading_i (hdg[g]),
      .vec_o     (vec[g+1]),
      .heading_o (hdg[g+1])
    );
  end

  rbtd_decide #(
    .ANGLE_WIDTH (ANGLE_WIDTH)
  ) u_decide (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .vec_i         (vec[NUM_CELLS]),
    .heading_i     (hdg[NUM_CELLS]),
    .threshold_i   (thresh_q),
    .out_stall_i   (out_stall_i),
    .advance_o     (advance),
    .out_valid_o   (out_valid_o),
    .turn_code_o   (turn_code_o),
    .angle_delta_o (angle_delta_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/rbtd_checker.sv =====
// Port-level checks for the relative bearing turn decision block, bound to
// the top level. Depends on rbtd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbtd_checker
  import rbtd_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_stall_o,
  input wire logic                  out_valid_o,
  input wire logic                  out_stall_i,
  input wire logic [1:0]            turn_code_o,
  input wire logic [DELTA_W-1:0]    angle_delta_o,
  input wire logic                  psel,
  input wire logic                  penable,
  input wire logic                  pwrite,
  input wire logic [APB_ADDR_W-1:0] paddr,
  input wire logic [APB_DATA_W-1:0] pwdata,
  input wire logic [APB_DATA_W-1:0] prdata
);

  // A held result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(turn_code_o)
                                   && $stable(angle_delta_o))
    else $error("held result beat changed");

  // Only the three defined turn codes appear.
  a_turn_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> turn_code_o != 2'd3)
    else $error("undefined turn code");

  // An empty output register never backpressures the input.
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // A threshold write reads back in the next cycle.
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && paddr[2] == REG_THRESHOLD ##1 paddr[2] == REG_THRESHOLD
    |-> prdata[THRESH_W-1:0] == $past(pwdata[THRESH_W-1:0]))
    else $error("threshold readback mismatch");

endmodule

bind relative_bearing_turn_decision rbtd_checker u_rbtd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .turn_code_o   (turn_code_o),
  .angle_delta_o (angle_delta_o),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata)
);

`default_nettype wire

// ===== tb/sv/relative_bearing_turn_decision_tb.sv =====
// Self-checking testbench for the relative bearing turn decision block.
// Drives queries through the valid/stall channel, checks each beat against a bit-true
// CORDIC bearing predictor, and steps the dead-zone register over the APB port. Needs rbtd_pkg.
`timescale 1ns / 1ps

module relative_bearing_turn_decision_tb;
  import rbtd_pkg::*;

  localparam int COORD_W  = 24;
  localparam int ANGLE_W  = 16;
  localparam int STAGES   = 16;
  localparam int COORD_MAX = 8388607;
  localparam int COORD_MIN = -8388608;

  typedef struct {
    logic               sp;
    logic               tp;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [COORD_W-1:0] tx;
    logic [COORD_W-1:0] ty;
    logic [ANGLE_W-1:0] hd;
  } query_t;

  typedef struct {
    turn_e              turn;
    logic [DELTA_W-1:0] delta;
  } bearing_res_t;

  // one directed probe; aim means hd is the wanted angle, not the heading
  typedef struct {
    int    thr;
    bit    sp;
    bit    tp;
    int    sx;
    int    sy;
    int    tx;
    int    ty;
    int    hd;
    bit    aim;
    bit    pin;
    turn_e exp_turn;
    int    exp_delta;
  } probe_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  self_present_i;
  logic                  target_present_i;
  logic [COORD_W-1:0]    self_x_i;
  logic [COORD_W-1:0]    self_y_i;
  logic [COORD_W-1:0]    target_x_i;
  logic [COORD_W-1:0]    target_y_i;
  logic [ANGLE_W-1:0]    self_heading_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [1:0]            turn_code_o;
  logic [DELTA_W-1:0]    angle_delta_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  relative_bearing_turn_decision #(
    .COORD_WIDTH  (COORD_W),
    .ANGLE_WIDTH  (ANGLE_W),
    .CORDIC_STAGES(STAGES)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .self_present_i  (self_present_i),
    .target_present_i(target_present_i),
    .self_x_i        (self_x_i),
    .self_y_i        (self_y_i),
    .target_x_i      (target_x_i),
    .target_y_i      (target_y_i),
    .self_heading_i  (self_heading_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .turn_code_o     (turn_code_o),
    .angle_delta_o   (angle_delta_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  bit [31:0]    atan_step [24];
  logic [15:0]  thresh_model;
  bearing_res_t pending_turns [$];
  probe_row_t   probe_tab [$];
  int           mismatch_cnt;
  int           queries_sent;
  int           beats_checked;
  int           settings_seen;
  int           gap_pct;
  int           stall_pct;
  bit           quiet;
  int           stall_left;
  bearing_res_t head_exp;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // guard against a hung run
  initial begin
    #10_000_000;
    $display("relative_bearing_turn_decision: mismatch");
    $finish;
  end

  // bearing of (target - self) by vectoring CORDIC, minus heading, then the dead zone
  function automatic bearing_res_t predict_turn(input query_t q);
    bearing_res_t r;
    longint       dx;
    longint       dy;
    longint       xv;
    longint       yv;
    longint       xs;
    longint       ys;
    bit [31:0]    z;
    bit [15:0]    brg;
    bit [15:0]    raw;
    int           delta;
    int           mag;
    r.turn  = TURN_NONE;
    r.delta = '0;
    if (!(q.sp && q.tp)) return r;
    dx = longint'($signed(q.tx)) - longint'($signed(q.sx));
    dy = longint'($signed(q.ty)) - longint'($signed(q.sy));
    if (dx == 0 && dy == 0) return r;
    xv = dx * (longint'(1) << (60 - COORD_W));
    yv = dy * (longint'(1) << (60 - COORD_W));
    z  = '0;
    // fold the left half plane over to the right
    if (xv < 0) begin
      xv = -xv;
      yv = -yv;
      z  = 32'h8000_0000;
    end
    for (int i = 0; i < STAGES && i < 24; i++) begin
      xs = xv >>> i;
      ys = yv >>> i;
      if (yv >= 0) begin
        xv = xv + ys;
        yv = yv - xs;
        z  = z + atan_step[i];
      end else begin
        xv = xv - ys;
        yv = yv + xs;
        z  = z - atan_step[i];
      end
    end
    brg = 16'((z + (32'd1 << (31 - ANGLE_W))) >> (32 - ANGLE_W));
    raw = brg - q.hd;
    delta = $signed(raw);
    mag = (delta < 0) ? -delta : delta;
    r.delta = raw;
    if (mag < int'(thresh_model)) r.turn = TURN_NONE;
    else r.turn = (delta > 0) ? TURN_RIGHT : TURN_LEFT;
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] pick_extreme();
    case ($urandom_range(0, 4))
      0:       return COORD_W'(COORD_MIN);
      1:       return COORD_W'(COORD_MAX);
      2:       return '0;
      3:       return '1;
      default: return COORD_W'(1);
    endcase
  endfunction

  // random query: full range, near offsets, coincident, axes, extremes, aimed at the dead zone
  function automatic query_t random_query();
    query_t       q;
    query_t       q0;
    bearing_res_t b;
    int           span;
    int           want;
    q.sp = ($urandom_range(0, 19) != 0);
    q.tp = ($urandom_range(0, 19) != 0);
    q.sx = COORD_W'($urandom);
    q.sy = COORD_W'($urandom);
    q.tx = COORD_W'($urandom);
    q.ty = COORD_W'($urandom);
    q.hd = ANGLE_W'($urandom);
    case ($urandom_range(0, 9))
      3, 4: begin
        span = 1 << $urandom_range(0, 12);
        q.tx = q.sx + COORD_W'($urandom_range(0, 2 * span)) - COORD_W'(span);
        q.ty = q.sy + COORD_W'($urandom_range(0, 2 * span)) - COORD_W'(span);
      end
      5: begin
        q.tx = q.sx;
        q.ty = q.sy;
      end
      6: begin
        span = 1 << $urandom_range(0, 22);
        if ($urandom_range(0, 1) == 1) begin
          q.ty = q.sy;
          q.tx = q.sx + COORD_W'($urandom_range(0, 2 * span)) - COORD_W'(span);
        end else begin
          q.tx = q.sx;
          q.ty = q.sy + COORD_W'($urandom_range(0, 2 * span)) - COORD_W'(span);
        end
      end
      7: begin
        q.sx = pick_extreme();
        q.sy = pick_extreme();
        q.tx = pick_extreme();
        q.ty = pick_extreme();
      end
      8, 9: begin
        q0 = q;
        q0.sp = 1'b1;
        q0.tp = 1'b1;
        q0.hd = '0;
        b = predict_turn(q0);
        case ($urandom_range(0, 5))
          0:       want = int'(thresh_model) + $urandom_range(0, 4) - 2;
          1:       want = -(int'(thresh_model) + $urandom_range(0, 4) - 2);
          2:       want = 32768;
          3:       want = 32767;
          4:       want = $urandom_range(0, 2) - 1;
          default: want = $urandom_range(0, 65535);
        endcase
        q.hd = b.delta - ANGLE_W'(want);
      end
      default: ;
    endcase
    return q;
  endfunction

  task automatic add_row(input int thr, input bit sp, input bit tp, input int sx, input int sy,
                         input int tx, input int ty, input int hd, input bit aim,
                         input bit pin, input turn_e et, input int ed);
    probe_row_t r;
    r.thr = thr;  r.sp = sp;  r.tp = tp;
    r.sx = sx;    r.sy = sy;  r.tx = tx;  r.ty = ty;
    r.hd = hd;    r.aim = aim;
    r.pin = pin;  r.exp_turn = et;  r.exp_delta = ed;
    probe_tab.push_back(r);
  endtask

  // drive one beat, hold until accepted, then maybe idle a burst
  task automatic push_query(input query_t q, input bearing_res_t e);
    in_valid_i       <= 1'b1;
    self_present_i   <= q.sp;
    target_present_i <= q.tp;
    self_x_i         <= q.sx;
    self_y_i         <= q.sy;
    target_x_i       <= q.tx;
    target_y_i       <= q.ty;
    self_heading_i   <= q.hd;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_turns.push_back(e);
    queries_sent++;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  // drop valid and hold until every expected beat is back
  task automatic wait_results();
    in_valid_i <= 1'b0;
    while (pending_turns.size() != 0) @(posedge clk_i);
  endtask

  // APB write of the dead-zone register; upper data bits are don't-care
  task automatic write_threshold(input logic [15:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_THRESHOLD, 2'b00};
    pwdata  <= {16'($urandom), v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    thresh_model = v;
    settings_seen++;
  endtask

  function automatic void log_mismatch(input string msg);
    if (mismatch_cnt < 10) $display("%t: %s", $realtime, msg);
    mismatch_cnt++;
  endfunction

  // receiver stall in random bursts
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if (rst_ni && !quiet && $urandom_range(0, 99) < stall_pct) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 8);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // compare each accepted output beat with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_turns.size() == 0) begin
        log_mismatch($sformatf("beat with nothing expected: turn %0d delta %h",
                               turn_code_o, angle_delta_o));
      end else begin
        head_exp = pending_turns.pop_front();
        beats_checked++;
        if (turn_code_o !== head_exp.turn || angle_delta_o !== head_exp.delta)
          log_mismatch($sformatf("beat %0d: expected turn %0d delta %h, got turn %0d delta %h",
                                 beats_checked, head_exp.turn, head_exp.delta,
                                 turn_code_o, angle_delta_o));
      end
    end
  end

  initial begin
    probe_row_t   row;
    query_t       q;
    query_t       q0;
    bearing_res_t e;
    bearing_res_t b;
    logic [15:0]  thr;

    atan_step = '{
      32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
    };
    thresh_model     = THRESH_RESET;
    mismatch_cnt     = 0;
    queries_sent     = 0;
    beats_checked    = 0;
    settings_seen    = 1;
    gap_pct          = 30;
    stall_pct        = 20;
    quiet            = 1'b0;
    stall_left       = 0;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    out_stall_i      = 1'b0;
    self_present_i   = 1'b0;
    target_present_i = 1'b0;
    self_x_i         = '0;
    self_y_i         = '0;
    target_x_i       = '0;
    target_y_i       = '0;
    self_heading_i   = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;

    // reset
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // absent parties and coincident points
    add_row(-1, 0, 1, 10, 20, 3000, -400, 0, 0, 1, TURN_NONE, 0);
    add_row(-1, 1, 0, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 65535, 0, 1, TURN_NONE, 0);
    add_row(-1, 0, 0, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 12345, 0, 1, TURN_NONE, 0);
    add_row(-1, 1, 1, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 777, 0, 1, TURN_NONE, 0);
    add_row(-1, 1, 1, 0, 0, 0, 0, 0, 0, 1, TURN_NONE, 0);
    // unit offsets on the axes, a diagonal, the widest offsets
    add_row(-1, 1, 1, 0, 0, 1, 0, 0, 0, 0, TURN_NONE, 0);
    add_row(-1, 1, 1, 0, 0, 0, 1, 0, 0, 0, TURN_NONE, 0);
    add_row(-1, 1, 1, 0, 0, -1, 0, 0, 0, 0, TURN_NONE, 0);
    add_row(-1, 1, 1, 0, 0, 0, -1, 0, 0, 0, TURN_NONE, 0);
    add_row(-1, 1, 1, 0, 0, 5000, 5000, 8192, 0, 0, TURN_NONE, 0);
    add_row(-1, 1, 1, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 0, 0, 0, TURN_NONE, 0);
    add_row(-1, 1, 1, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 65535, 0, 0, TURN_NONE, 0);
    // far west, just above, just below and on the branch cut
    add_row(-1, 1, 1, COORD_MAX, 0, COORD_MIN, 1, 0, 0, 0, TURN_NONE, 0);
    add_row(-1, 1, 1, COORD_MAX, 0, COORD_MIN, -1, 0, 0, 0, TURN_NONE, 0);
    add_row(-1, 1, 1, COORD_MAX, 0, COORD_MIN, 0, 32768, 0, 0, TURN_NONE, 0);
    // dead zone edges at the reset threshold
    add_row(-1, 1, 1, 100, -200, -3000, 7000, 1820, 1, 0, TURN_NONE, 0);
    add_row(-1, 1, 1, 100, -200, -3000, 7000, 1819, 1, 0, TURN_NONE, 0);
    add_row(-1, 1, 1, 100, -200, -3000, 7000, -1820, 1, 0, TURN_NONE, 0);
    add_row(-1, 1, 1, 100, -200, -3000, 7000, -1, 1, 1, TURN_NONE, 65535);
    // zero threshold: zero angle and half turn both go left
    add_row(0, 1, 1, -40, 90, 600, -17, 0, 1, 1, TURN_LEFT, 0);
    add_row(0, 1, 1, -40, 90, 600, -17, 32768, 1, 1, TURN_LEFT, 32768);
    // widest dead zone
    add_row(32768, 1, 1, 5, 5, -9000, 123, 32768, 1, 1, TURN_LEFT, 32768);
    add_row(32768, 1, 1, 5, 5, -9000, 123, 32767, 1, 1, TURN_NONE, 32767);
    add_row(32768, 1, 1, 1, 2, 300, 400, 5000, 0, 0, TURN_NONE, 0);
    add_row(1820, 1, 1, 0, 0, 2, -7, 4000, 0, 0, TURN_NONE, 0);

    // walk the directed table
    foreach (probe_tab[i]) begin
      row = probe_tab[i];
      if (row.thr >= 0 && 16'(row.thr) != thresh_model) begin
        wait_results();
        write_threshold(16'(row.thr));
      end
      q.sp = row.sp;
      q.tp = row.tp;
      q.sx = COORD_W'(row.sx);
      q.sy = COORD_W'(row.sy);
      q.tx = COORD_W'(row.tx);
      q.ty = COORD_W'(row.ty);
      q.hd = ANGLE_W'(row.hd);
      if (row.aim) begin
        q0 = q;
        q0.hd = '0;
        b = predict_turn(q0);
        q.hd = b.delta - ANGLE_W'(row.hd);
      end
      if (row.pin) begin
        e.turn  = row.exp_turn;
        e.delta = DELTA_W'(row.exp_delta);
      end else begin
        e = predict_turn(q);
      end
      push_query(q, e);
    end

    // random phases over several dead-zone settings
    for (int ph = 0; ph < 7; ph++) begin
      wait_results();
      case (ph)
        0:       thr = 16'd1820;
        1:       thr = 16'd0;
        2:       thr = 16'd32768;
        3:       thr = 16'($urandom_range(0, 32768));
        4:       thr = 16'($urandom_range(0, 64));
        5:       thr = 16'd1;
        default: thr = 16'($urandom_range(0, 32768));
      endcase
      write_threshold(thr);
      gap_pct   = $urandom_range(0, 60);
      stall_pct = $urandom_range(0, 50);
      for (int n = 0; n < 220; n++) begin
        q = random_query();
        push_query(q, predict_turn(q));
        // hold off once until the pipeline has emptied
        if (ph == 3 && n == 110) wait_results();
      end
    end

    // closing stretch at full rate
    quiet     = 1'b1;
    gap_pct   = 0;
    stall_pct = 0;
    for (int n = 0; n < 200; n++) begin
      q = random_query();
      push_query(q, predict_turn(q));
    end
    wait_results();
    repeat (40) @(posedge clk_i);

    $display("run covered %0d queries and %0d checked beats", queries_sent, beats_checked);
    $display("dead zone visited %0d settings, %0d mismatches", settings_seen, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("relative_bearing_turn_decision: match");
    end else begin
      $display("relative_bearing_turn_decision: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/rbtd_pkg.sv
rtl/core/rbtd_prep.sv
rtl/core/rbtd_cell.sv
rtl/core/rbtd_decide.sv
rtl/core/relative_bearing_turn_decision.sv
rtl/core/rbtd_checker.sv
tb/sv/relative_bearing_turn_decision_tb.sv
